/* rtl/core/k_way_merge_sorted_heads_top_macros.svh */
// assertion macros shared by the merge checker
`ifndef K_WAY_MERGE_SORTED_HEADS_TOP_MACROS_SVH
`define K_WAY_MERGE_SORTED_HEADS_TOP_MACROS_SVH

// same-cycle implication, checked outside reset
`define KWM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("merge check failed");

// next-cycle implication, checked outside reset
`define KWM_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("merge check failed");

`endif

/* rtl/core/kwm_pkg.sv */
// shared types and codes of the k-way merge block
package kwm_pkg;

    // fixed beat field widths
    localparam int CMD_BITS     = 2;
    localparam int STATUS_BITS  = 2;
    localparam int RUN_BITS     = 3;
    localparam int KEY_BITS     = 32;
    localparam int PAYLOAD_BITS = 32;
    localparam int WAYS_BITS    = 4;

    // ways register value after reset
    localparam logic [WAYS_BITS-1:0] WAYS_RESET = 4'd8;

    // run report codes (any other code counts as a failure)
    localparam logic [CMD_BITS-1:0] CMD_TUPLE = 2'd0;
    localparam logic [CMD_BITS-1:0] CMD_END   = 2'd1;
    localparam logic [CMD_BITS-1:0] CMD_FAIL  = 2'd2;

    // result status codes
    localparam logic [STATUS_BITS-1:0] STAT_TUPLE = 2'd0;
    localparam logic [STATUS_BITS-1:0] STAT_DONE  = 2'd1;
    localparam logic [STATUS_BITS-1:0] STAT_FAIL  = 2'd2;

    // input beat
    typedef struct packed {
        logic [CMD_BITS-1:0]     command;
        logic [KEY_BITS-1:0]     key;
        logic [PAYLOAD_BITS-1:0] payload;
    } kwm_item_t;

    // output beat
    typedef struct packed {
        logic [STATUS_BITS-1:0]  status;
        logic [RUN_BITS-1:0]     run_number;
        logic [KEY_BITS-1:0]     out_key;
        logic [PAYLOAD_BITS-1:0] out_payload;
    } kwm_result_t;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INS_CHK,
        ST_INS_CMP,
        ST_EMIT_RD,
        ST_EMIT_GET,
        ST_OUT
    } kwm_state_t;

endpackage

/* rtl/core/kwm_ram.sv */
// generic single-write, single-read ram with registered read data
module kwm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
)(
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* rtl/core/k_way_merge_sorted_heads_top.sv */
// k-way merge: a report is taken in ST_IDLE; a tuple adds an insertion that walks the
// sorted list from its tail, ST_INS_CHK then ST_INS_CMP per head moved past; a tuple or
// run end while merging or last in the load adds an emit: ST_EMIT_RD reads the head,
// ST_EMIT_GET pops it, ST_OUT waits for the output register; one report at a time
// async active-low reset: load phase, empty list, ways_in_use = 8; ram is not cleared
module k_way_merge_sorted_heads_top
    import kwm_pkg::*;
#(
    parameter int MAX_WAYS      = 8,
    parameter int KEY_WIDTH     = 32,
    parameter int PAYLOAD_WIDTH = 32
)(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_stall,
    input  kwm_item_t            item,
    output logic                 result_valid,
    input  logic                 result_stall,
    output kwm_result_t          result,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [WAYS_BITS-1:0] cfg_data
);

    localparam int IW      = $clog2(MAX_WAYS);
    localparam int CW      = $clog2(MAX_WAYS + 1);
    localparam int CMPW    = (CW > WAYS_BITS) ? CW : WAYS_BITS;
    localparam int KEY_EXT = (KEY_WIDTH > KEY_BITS) ? KEY_WIDTH : KEY_BITS;
    localparam int PAY_EXT = (PAYLOAD_WIDTH > PAYLOAD_BITS) ? PAYLOAD_WIDTH : PAYLOAD_BITS;
    localparam int RUN_EXT = (IW > RUN_BITS) ? IW : RUN_BITS;
    localparam int EW      = KEY_WIDTH + PAYLOAD_WIDTH + IW;

    kwm_state_t               state_reg, state_next;
    logic [WAYS_BITS-1:0]     ways_reg, ways_next;
    logic                     phase_reg, phase_next;
    logic [CW-1:0]            load_cnt_reg, load_cnt_next;
    logic [CW-1:0]            len_reg, len_next;
    logic [CW-1:0]            idx_reg, idx_next;
    logic [IW-1:0]            pend_reg, pend_next;
    logic [IW-1:0]            head_reg, head_next;
    logic                     emit_reg, emit_next;
    logic [IW-1:0]            nrun_reg, nrun_next;
    logic [KEY_WIDTH-1:0]     nkey_reg, nkey_next;
    logic [PAYLOAD_WIDTH-1:0] npay_reg, npay_next;
    logic [STATUS_BITS-1:0]   rstat_reg, rstat_next;
    logic [IW-1:0]            rrun_reg, rrun_next;
    logic [KEY_WIDTH-1:0]     rkey_reg, rkey_next;
    logic [PAYLOAD_WIDTH-1:0] rpay_reg, rpay_next;
    logic                     res_valid_reg, res_valid_next;
    kwm_result_t              res_data_reg, res_data_next;

    logic                     ram_we, ram_re;
    logic [IW-1:0]            ram_waddr, ram_raddr;
    logic [EW-1:0]            ram_wdata, ram_rdata;

    logic                     accept;
    logic                     is_fail;
    logic                     do_emit;
    logic                     list_full;
    logic                     out_free;
    logic                     key_shift;
    logic [IW-1:0]            run_sel;
    logic [CMPW-1:0]          ways_nz, eff_ways, cnt_inc;
    logic [KEY_EXT-1:0]       key_in_ext, key_out_ext;
    logic [PAY_EXT-1:0]       pay_in_ext, pay_out_ext;
    logic [RUN_EXT-1:0]       run_out_ext;
    logic [KEY_WIDTH-1:0]     rd_key;
    logic [PAYLOAD_WIDTH-1:0] rd_pay;
    logic [IW-1:0]            rd_run;
    logic [EW-1:0]            new_entry;
    logic [IW-1:0]            pos_at_idx, pos_before_idx, head_inc;

    // list position with wrap at the list capacity
    function automatic logic [IW-1:0] wrap_pos(input logic [IW:0] sum);
        logic [IW:0] adj;
        begin
            adj = sum - (IW+1)'(MAX_WAYS);
            wrap_pos = (sum >= (IW+1)'(MAX_WAYS)) ? adj[IW-1:0] : sum[IW-1:0];
        end
    endfunction

    // sorted list of run heads, circular from head_reg: {key, payload, run}
    kwm_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_WAYS)
    ) u_list (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    // handshake and port views
    assign accept       = item_valid && (state_reg == ST_IDLE);
    assign item_stall   = (state_reg != ST_IDLE);
    assign cfg_ready    = 1'b1;
    assign result_valid = res_valid_reg;
    assign result       = res_data_reg;
    assign out_free     = !res_valid_reg || !result_stall;

    // report decode and run selection
    assign is_fail = (item.command != CMD_TUPLE) && (item.command != CMD_END);
    assign run_sel = phase_reg ? pend_reg : load_cnt_reg[IW-1:0];

    // effective way count and end of load
    assign ways_nz   = (ways_reg == '0) ? CMPW'(1) : CMPW'(ways_reg);
    assign eff_ways  = (ways_nz > CMPW'(MAX_WAYS)) ? CMPW'(MAX_WAYS) : ways_nz;
    assign cnt_inc   = CMPW'(load_cnt_reg) + CMPW'(1);
    assign do_emit   = phase_reg || (cnt_inc >= eff_ways);
    assign list_full = (len_reg == CW'(MAX_WAYS));

    // width adaptation of key and payload
    assign key_in_ext  = KEY_EXT'(item.key);
    assign pay_in_ext  = PAY_EXT'(item.payload);
    assign key_out_ext = KEY_EXT'(rkey_reg);
    assign pay_out_ext = PAY_EXT'(rpay_reg);
    assign run_out_ext = RUN_EXT'(rrun_reg);

    // list entry fields
    assign rd_key    = ram_rdata[EW-1 -: KEY_WIDTH];
    assign rd_pay    = ram_rdata[IW +: PAYLOAD_WIDTH];
    assign rd_run    = ram_rdata[IW-1:0];
    assign new_entry = {nkey_reg, npay_reg, nrun_reg};
    assign key_shift = (rd_key >= nkey_reg);

    // list positions
    assign pos_at_idx     = wrap_pos((IW+1)'(head_reg) + (IW+1)'(idx_reg));
    assign pos_before_idx = wrap_pos((IW+1)'(head_reg) + (IW+1)'(idx_reg - CW'(1)));
    assign head_inc       = wrap_pos((IW+1)'(head_reg) + (IW+1)'(1));

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (is_fail)
                    begin
                        state_next = ST_OUT;
                    end
                    else if ((item.command == CMD_TUPLE) && !list_full)
                    begin
                        state_next = ST_INS_CHK;
                    end
                    else if (do_emit)
                    begin
                        state_next = ST_EMIT_RD;
                    end
                end
            end
            ST_INS_CHK:
            begin
                if (idx_reg == '0)
                begin
                    state_next = emit_reg ? ST_EMIT_RD : ST_IDLE;
                end
                else
                begin
                    state_next = ST_INS_CMP;
                end
            end
            ST_INS_CMP:
            begin
                if (key_shift)
                begin
                    state_next = ST_INS_CHK;
                end
                else
                begin
                    state_next = emit_reg ? ST_EMIT_RD : ST_IDLE;
                end
            end
            ST_EMIT_RD:
            begin
                state_next = (len_reg == '0) ? ST_OUT : ST_EMIT_GET;
            end
            ST_EMIT_GET:
            begin
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath, ram control and result staging
    always_comb
    begin
        ways_next      = cfg_valid ? cfg_data : ways_reg;
        phase_next     = phase_reg;
        load_cnt_next  = load_cnt_reg;
        len_next       = len_reg;
        idx_next       = idx_reg;
        pend_next      = pend_reg;
        head_next      = head_reg;
        emit_next      = emit_reg;
        nrun_next      = nrun_reg;
        nkey_next      = nkey_reg;
        npay_next      = npay_reg;
        rstat_next     = rstat_reg;
        rrun_next      = rrun_reg;
        rkey_next      = rkey_reg;
        rpay_next      = rpay_reg;
        res_valid_next = res_valid_reg && result_stall;
        res_data_next  = res_data_reg;
        ram_we         = 1'b0;
        ram_re         = 1'b0;
        ram_waddr      = pos_at_idx;
        ram_wdata      = new_entry;
        ram_raddr      = pos_before_idx;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    // latch the report
                    nkey_next = key_in_ext[KEY_WIDTH-1:0];
                    npay_next = pay_in_ext[PAYLOAD_WIDTH-1:0];
                    nrun_next = run_sel;
                    idx_next  = len_reg;
                    emit_next = do_emit;
                    if (!phase_reg)
                    begin
                        load_cnt_next = load_cnt_reg + CW'(1);
                    end
                    // failure abandons the merge
                    if (is_fail)
                    begin
                        rstat_next    = STAT_FAIL;
                        rrun_next     = run_sel;
                        rkey_next     = '0;
                        rpay_next     = '0;
                        phase_next    = 1'b0;
                        load_cnt_next = '0;
                        len_next      = '0;
                        pend_next     = '0;
                    end
                end
            end
            ST_INS_CHK:
            begin
                // reached the front: place the new head here
                if (idx_reg == '0)
                begin
                    ram_we    = 1'b1;
                    ram_wdata = new_entry;
                    len_next  = len_reg + CW'(1);
                end
                else
                begin
                    ram_re = 1'b1;
                end
            end
            ST_INS_CMP:
            begin
                // move an equal or larger head back, else place the new one
                ram_we = 1'b1;
                if (key_shift)
                begin
                    ram_wdata = ram_rdata;
                    idx_next  = idx_reg - CW'(1);
                end
                else
                begin
                    ram_wdata = new_entry;
                    len_next  = len_reg + CW'(1);
                end
            end
            ST_EMIT_RD:
            begin
                if (len_reg == '0)
                begin
                    // list empty: merge finished
                    rstat_next    = STAT_DONE;
                    rrun_next     = '0;
                    rkey_next     = '0;
                    rpay_next     = '0;
                    phase_next    = 1'b0;
                    load_cnt_next = '0;
                    pend_next     = '0;
                end
                else
                begin
                    ram_re    = 1'b1;
                    ram_raddr = head_reg;
                end
            end
            ST_EMIT_GET:
            begin
                // pop the smallest head and wait for its run
                rstat_next = STAT_TUPLE;
                rrun_next  = rd_run;
                rkey_next  = rd_key;
                rpay_next  = rd_pay;
                head_next  = head_inc;
                len_next   = len_reg - CW'(1);
                pend_next  = rd_run;
                phase_next = 1'b1;
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    res_valid_next            = 1'b1;
                    res_data_next.status      = rstat_reg;
                    res_data_next.run_number  = run_out_ext[RUN_BITS-1:0];
                    res_data_next.out_key     = key_out_ext[KEY_BITS-1:0];
                    res_data_next.out_payload = pay_out_ext[PAYLOAD_BITS-1:0];
                end
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ways_reg      <= WAYS_RESET;
            phase_reg     <= 1'b0;
            load_cnt_reg  <= '0;
            len_reg       <= '0;
            idx_reg       <= '0;
            pend_reg      <= '0;
            head_reg      <= '0;
            emit_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ways_reg      <= ways_next;
            phase_reg     <= phase_next;
            load_cnt_reg  <= load_cnt_next;
            len_reg       <= len_next;
            idx_reg       <= idx_next;
            pend_reg      <= pend_next;
            head_reg      <= head_next;
            emit_reg      <= emit_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        nrun_reg     <= nrun_next;
        nkey_reg     <= nkey_next;
        npay_reg     <= npay_next;
        rstat_reg    <= rstat_next;
        rrun_reg     <= rrun_next;
        rkey_reg     <= rkey_next;
        rpay_reg     <= rpay_next;
        res_data_reg <= res_data_next;
    end

endmodule

/* rtl/core/kwm_checker.sv */
// port-level checks of the k-way merge block and their bind
`include "k_way_merge_sorted_heads_top_macros.svh"

module kwm_checker
    import kwm_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        result_valid,
    input logic        result_stall,
    input kwm_result_t result
);

    // no status code beyond the three defined ones
    `KWM_ASSERT_IMP(a_status_known, clk, rst_n, result_valid, (result.status == STAT_TUPLE) || (result.status == STAT_DONE) || (result.status == STAT_FAIL))

    // finished and failure beats carry no tuple
    `KWM_ASSERT_IMP(a_no_tuple_data, clk, rst_n, result_valid && (result.status != STAT_TUPLE), (result.out_key == '0) && (result.out_payload == '0))

    // finished beat names no run
    `KWM_ASSERT_IMP(a_done_run_zero, clk, rst_n, result_valid && (result.status == STAT_DONE), result.run_number == '0)

    // a stalled result beat holds
    `KWM_ASSERT_NXT(a_result_hold, clk, rst_n, result_valid && result_stall, result_valid && $stable(result))

endmodule

bind k_way_merge_sorted_heads_top kwm_checker u_kwm_checker (.*);

/* tb/tb.sv */
// self-checking testbench for the k-way sorted-head merge block
`timescale 1ns / 100ps

module tb;
    import kwm_pkg::*;

    localparam int MAX_WAYS      = 8;
    localparam int RANDOM_ITEMS  = 1800;
    localparam int SETTLE_CYCLES = 40;
    localparam int DRAIN_LIMIT   = 20000;
    localparam int HOLD_CYCLES   = 400;

    // one step of the directed walk: a ways write or a report beat
    typedef struct packed {
        bit                    is_cfg;
        logic [WAYS_BITS-1:0]  ways;
        kwm_item_t             beat;
        bit                    typed;
        kwm_result_t           want;
    } dir_row_t;

    logic                 clk;
    logic                 rst_n;
    logic                 item_valid;
    logic                 item_stall;
    kwm_item_t            item;
    logic                 result_valid;
    logic                 result_stall;
    kwm_result_t          result;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [WAYS_BITS-1:0] cfg_data;

    // merge predictor state
    logic [KEY_BITS-1:0]     head_key_m [MAX_WAYS];
    logic [PAYLOAD_BITS-1:0] head_pay_m [MAX_WAYS];
    logic [RUN_BITS-1:0]     order_m [MAX_WAYS];
    int                      list_len_m = 0;
    bit                      merging_m  = 0;
    int                      loads_m    = 0;
    logic [RUN_BITS-1:0]     pending_m  = '0;
    logic [WAYS_BITS-1:0]    ways_m     = WAYS_RESET;

    kwm_result_t merge_out_q[$];
    dir_row_t    directed_q[$];
    int          mismatch_count = 0;
    int          burst_left     = 0;
    bit          hold_armed     = 0;

    k_way_merge_sorted_heads_top i_dut (
        .clk,
        .rst_n,
        .item_valid,
        .item_stall,
        .item,
        .result_valid,
        .result_stall,
        .result,
        .cfg_valid,
        .cfg_ready,
        .cfg_data
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // hard stop
    initial
    begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

    task automatic report_mismatch(input string what);
        if (mismatch_count < 40)
            $display("ERROR @%0t: %s", $realtime, what);
        mismatch_count++;
    endtask

    // advance the merge by one run report; returns 1 when a result beat follows
    function automatic bit merge_step(input kwm_item_t b, output kwm_result_t r);
        logic [RUN_BITS-1:0] run;
        int pos;
        int lim;
        run = merging_m ? pending_m : loads_m[RUN_BITS-1:0];
        r = '0;
        lim = (ways_m == 0) ? 1 : ((ways_m > MAX_WAYS) ? MAX_WAYS : int'(ways_m));
        // failure report, command three included, abandons the merge
        if (b.command != CMD_TUPLE && b.command != CMD_END)
        begin
            r.status     = STAT_FAIL;
            r.run_number = run;
            merging_m    = 0;
            loads_m      = 0;
            list_len_m   = 0;
            pending_m    = '0;
            return 1;
        end
        // sorted insert, new head ahead of equal keys
        if (b.command == CMD_TUPLE && list_len_m < MAX_WAYS)
        begin
            head_key_m[run] = b.key;
            head_pay_m[run] = b.payload;
            pos = 0;
            while (pos < list_len_m && head_key_m[order_m[pos]] < b.key)
                pos++;
            for (int i = list_len_m; i > pos; i--)
                order_m[i] = order_m[i-1];
            order_m[pos] = run;
            list_len_m++;
        end
        if (!merging_m)
        begin
            loads_m++;
            if (loads_m < lim)
                return 0;
        end
        // empty list closes the merge
        if (list_len_m == 0)
        begin
            r.status  = STAT_DONE;
            merging_m = 0;
            loads_m   = 0;
            pending_m = '0;
            return 1;
        end
        // pop the smallest head
        pending_m = order_m[0];
        for (int i = 1; i < list_len_m; i++)
            order_m[i-1] = order_m[i];
        list_len_m--;
        merging_m     = 1;
        r.status      = STAT_TUPLE;
        r.run_number  = pending_m;
        r.out_key     = head_key_m[pending_m];
        r.out_payload = head_pay_m[pending_m];
        return 1;
    endfunction

    function automatic dir_row_t beat_row(input logic [CMD_BITS-1:0] cmd,
                                          input logic [KEY_BITS-1:0] key,
                                          input logic [PAYLOAD_BITS-1:0] pay);
        dir_row_t row;
        row = '0;
        row.beat.command = cmd;
        row.beat.key     = key;
        row.beat.payload = pay;
        return row;
    endfunction

    function automatic dir_row_t checked_row(input logic [CMD_BITS-1:0] cmd,
                                             input logic [KEY_BITS-1:0] key,
                                             input logic [PAYLOAD_BITS-1:0] pay,
                                             input logic [STATUS_BITS-1:0] status,
                                             input logic [RUN_BITS-1:0] run,
                                             input logic [KEY_BITS-1:0] okey,
                                             input logic [PAYLOAD_BITS-1:0] opay);
        dir_row_t row;
        row = beat_row(cmd, key, pay);
        row.typed            = 1'b1;
        row.want.status      = status;
        row.want.run_number  = run;
        row.want.out_key     = okey;
        row.want.out_payload = opay;
        return row;
    endfunction

    function automatic dir_row_t cfg_row(input logic [WAYS_BITS-1:0] w);
        dir_row_t row;
        row = '0;
        row.is_cfg = 1'b1;
        row.ways   = w;
        return row;
    endfunction

    // offer one report beat in bursts, hold it until taken, then predict
    task automatic offer_beat(input kwm_item_t b, input bit typed, input kwm_result_t want);
        kwm_result_t got;
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(1, 12);
            @(negedge clk);
            item_valid = 1'b0;
            repeat (gap) @(negedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 16);
        end
        else
            @(negedge clk);
        item       = b;
        item_valid = 1'b1;
        do @(posedge clk); while (item_stall);
        burst_left--;
        if (merge_step(b, got))
            merge_out_q.push_back(typed ? want : got);
    endtask

    // ways write once the block has gone quiet
    task automatic write_ways(input logic [WAYS_BITS-1:0] w);
        @(negedge clk);
        item_valid = 1'b0;
        while (merge_out_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
        cfg_data  = w;
        cfg_valid = 1'b1;
        do @(posedge clk); while (!cfg_ready);
        ways_m = w;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            if (merge_out_q.size() == 0)
                report_mismatch("result beat with nothing expected");
            else
            begin
                if (result.status !== merge_out_q[0].status)
                    report_mismatch($sformatf("status %0d, expected %0d",
                                              result.status, merge_out_q[0].status));
                if (result.run_number !== merge_out_q[0].run_number)
                    report_mismatch($sformatf("run_number %0d, expected %0d",
                                              result.run_number, merge_out_q[0].run_number));
                if (result.out_key !== merge_out_q[0].out_key)
                    report_mismatch($sformatf("out_key %h, expected %h",
                                              result.out_key, merge_out_q[0].out_key));
                if (result.out_payload !== merge_out_q[0].out_payload)
                    report_mismatch($sformatf("out_payload %h, expected %h",
                                              result.out_payload, merge_out_q[0].out_payload));
                void'(merge_out_q.pop_front());
            end
        end
    end

    // receiver stall pattern, with one long hold-off during the random part
    initial
    begin
        int mode;
        int len;
        bit held;
        held         = 0;
        result_stall = 1'b0;
        forever
        begin
            mode = $urandom_range(0, 3);
            len  = $urandom_range(10, 80);
            repeat (len)
            begin
                @(negedge clk);
                case (mode)
                    0: result_stall = 1'b0;
                    1: result_stall = 1'($urandom_range(0, 1));
                    2: result_stall = ($urandom_range(0, 7) == 0);
                    default: result_stall = ($urandom_range(0, 3) != 0);
                endcase
            end
            if (hold_armed && !held)
            begin
                @(negedge clk);
                result_stall = 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                result_stall = 1'b0;
                held = 1;
            end
        end
    end

    // stimulus
    initial
    begin
        dir_row_t             row;
        kwm_item_t            b;
        logic [RUN_BITS-1:0]  r;
        logic [WAYS_BITS-1:0] w;
        logic [KEY_BITS-1:0]  last_key [MAX_WAYS];
        int                   run_left [MAX_WAYS];
        int                   sent;
        int                   merges;
        int                   dice;
        int                   spins;

        rst_n      = 1'b0;
        item_valid = 1'b0;
        item       = '0;
        cfg_valid  = 1'b0;
        cfg_data   = '0;
        sent       = 0;
        merges     = 0;
        spins      = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // eight ways after reset: extremes, run ends in the load, ties on key 5
        directed_q.push_back(beat_row(CMD_TUPLE, 32'h0000_0000, 32'h0000_0000));
        directed_q.push_back(beat_row(CMD_TUPLE, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        directed_q.push_back(beat_row(CMD_END,   32'h0000_0000, 32'h0000_0000));
        directed_q.push_back(beat_row(CMD_TUPLE, 32'h0000_0005, 32'h0000_0033));
        directed_q.push_back(beat_row(CMD_END,   32'hFFFF_FFFF, 32'hFFFF_FFFF));
        directed_q.push_back(beat_row(CMD_TUPLE, 32'h0000_0005, 32'h0000_0055));
        directed_q.push_back(beat_row(CMD_END,   32'h0000_0000, 32'h0000_0000));
        directed_q.push_back(checked_row(CMD_TUPLE, 32'h8000_0000, 32'h0000_0077,
                                         STAT_TUPLE, 3'd0, 32'h0, 32'h0));
        directed_q.push_back(beat_row(CMD_END,   32'h0000_0000, 32'h0000_0000));
        // refill of run 5 with an equal key goes ahead of run 3
        directed_q.push_back(beat_row(CMD_TUPLE, 32'h0000_0005, 32'h0000_00A5));
        directed_q.push_back(beat_row(CMD_END,   32'h0000_0000, 32'h0000_0000));
        directed_q.push_back(beat_row(CMD_END,   32'h0000_0000, 32'h0000_0000));
        directed_q.push_back(checked_row(CMD_END, 32'h0, 32'h0,
                                         STAT_TUPLE, 3'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        directed_q.push_back(checked_row(CMD_END, 32'h0, 32'h0,
                                         STAT_DONE, 3'd0, 32'h0, 32'h0));
        // zero ways acts as one, command three fails the merge
        directed_q.push_back(cfg_row(4'd0));
        directed_q.push_back(beat_row(CMD_TUPLE, 32'h0000_0007, 32'h0000_0001));
        directed_q.push_back(checked_row(2'd3, 32'h0, 32'h0, STAT_FAIL, 3'd0, 32'h0, 32'h0));
        // ways above the maximum saturate, failure during the load
        directed_q.push_back(cfg_row(4'd15));
        directed_q.push_back(beat_row(CMD_TUPLE, 32'h0000_0009, 32'h0000_0002));
        directed_q.push_back(checked_row(CMD_FAIL, 32'h0, 32'h0, STAT_FAIL, 3'd1, 32'h0, 32'h0));
        // every run ended in the load: finished at once
        directed_q.push_back(cfg_row(4'd3));
        directed_q.push_back(beat_row(CMD_END, 32'h0000_0000, 32'h0000_0000));
        directed_q.push_back(beat_row(CMD_END, 32'h0000_0000, 32'h0000_0000));
        directed_q.push_back(checked_row(CMD_END, 32'h0, 32'h0, STAT_DONE, 3'd0, 32'h0, 32'h0));
        // ways lowered in the middle of a load, then failure while merging
        directed_q.push_back(cfg_row(4'd5));
        directed_q.push_back(beat_row(CMD_TUPLE, 32'h0000_0020, 32'h0000_0003));
        directed_q.push_back(beat_row(CMD_TUPLE, 32'h0000_0010, 32'h0000_0004));
        directed_q.push_back(cfg_row(4'd2));
        directed_q.push_back(beat_row(CMD_TUPLE, 32'h0000_0018, 32'h0000_0005));
        directed_q.push_back(checked_row(CMD_FAIL, 32'h0, 32'h0, STAT_FAIL, 3'd1, 32'h0, 32'h0));

        foreach (directed_q[i])
        begin
            row = directed_q[i];
            if (row.is_cfg)
                write_ways(row.ways);
            else
                offer_beat(row.beat, row.typed, row.want);
        end

        // random merges of mostly ascending runs, with failures and broken order
        hold_armed = 1;
        while (sent < RANDOM_ITEMS)
        begin
            if (!merging_m && loads_m == 0)
            begin
                if (merges % 3 == 0)
                begin
                    dice = $urandom_range(0, 9);
                    if (dice == 0)
                        w = 4'd0;
                    else if (dice == 1)
                        w = WAYS_BITS'($urandom_range(9, 15));
                    else
                        w = WAYS_BITS'($urandom_range(1, 8));
                    write_ways(w);
                end
                merges++;
                for (int i = 0; i < MAX_WAYS; i++)
                begin
                    run_left[i] = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 6);
                    case ($urandom_range(0, 2))
                        0: last_key[i] = $urandom;
                        1: last_key[i] = $urandom_range(0, 4);
                        default: last_key[i] = 32'hFFFF_FFF0 + $urandom_range(0, 8);
                    endcase
                end
            end
            r    = merging_m ? pending_m : loads_m[RUN_BITS-1:0];
            dice = $urandom_range(0, 99);
            b.key     = $urandom;
            b.payload = $urandom;
            if (dice == 0)
                b.command = CMD_FAIL;
            else if (dice == 1)
                b.command = 2'd3;
            else if (dice < 5)
                b.command = CMD_BITS'($urandom_range(0, 1));
            else
                b.command = (run_left[r] == 0) ? CMD_END : CMD_TUPLE;
            if (b.command == CMD_TUPLE)
            begin
                if ($urandom_range(0, 19) != 0)
                    b.key = last_key[r] + KEY_BITS'($urandom_range(0, 3));
                last_key[r] = b.key;
                if (run_left[r] > 0)
                    run_left[r]--;
            end
            offer_beat(b, 1'b0, '0);
            sent++;
        end

        // drain
        @(negedge clk);
        item_valid = 1'b0;
        while (merge_out_q.size() != 0 && spins < DRAIN_LIMIT)
        begin
            @(posedge clk);
            spins++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (merge_out_q.size() != 0)
            report_mismatch($sformatf("%0d result beats never arrived", merge_out_q.size()));

        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
